[rtl/goc_pkg.sv]
// ----------------------------------------------------------------------------
// goc_pkg
// Types, constants and helpers shared by the occupancy calculator pipeline.
// ----------------------------------------------------------------------------
package goc_pkg;

  localparam int LANES     = 8;   // lane 0 is the requested block size
  localparam int TRIALS    = 7;
  localparam int SIZE_W    = 11;
  localparam int BLK_W     = 7;   // resident blocks never exceed the block limit
  localparam int DIV_W     = 20;
  localparam int QUO_STEPS = 11;
  localparam int QUO_W     = QUO_STEPS + 1;
  localparam int DIV_LAT   = QUO_STEPS + 1;
  localparam int OCC_W     = BLK_W + SIZE_W;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 3;

  localparam logic [SIZE_W-1:0] MAX_BLOCK_THREADS = 11'd1024;

  localparam logic [SIZE_W-1:0] TRIAL_TABLE [TRIALS] =
    '{11'd32, 11'd64, 11'd128, 11'd256, 11'd512, 11'd768, 11'd1024};

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FN  = 2'd1;
  localparam logic [1:0] STATUS_BS_ZERO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THREADS_PER_SM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARP_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGS_PER_SM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMEM_PER_SM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SM_COUNT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COOP_SUPPORTED = 3'd6;

  typedef struct packed {
    logic        is_function;
    logic [7:0]  regs_per_thread;
    logic [18:0] static_smem_bytes;
    logic [18:0] dynamic_smem_bytes;
    logic [10:0] blk_threads;
    logic [10:0] blk_threads_cap;
    logic [10:0] kernel_max_threads;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] max_active_blocks;
    logic [22:0] cooperative_blocks;
    logic [10:0] best_blk_threads;
    logic [22:0] min_grid_size;
  } res_t;

  // per-transaction fields carried alongside the datapath
  typedef struct packed {
    logic              is_function;
    logic [7:0]        regs;
    logic [DIV_W-1:0]  smem_total;
    logic [SIZE_W-1:0] blk_threads;
    logic [SIZE_W-1:0] cap;
  } ctx_t;

  function automatic logic [SIZE_W-1:0] lane_size(logic [SIZE_W-1:0] bs, int lane);
    logic [SIZE_W-1:0] sz;
    if (lane == 0) sz = bs;
    else sz = TRIAL_TABLE[lane-1];
    return sz;
  endfunction

endpackage

[rtl/goc_div.sv]
// ----------------------------------------------------------------------------
// goc_div
// Pipelined restoring divider, one quotient bit per stage. Quotients of
// 2048 or more saturate to 2048; the remainder is only good when unsaturated.
// ----------------------------------------------------------------------------
module goc_div (
  input  logic                       clk,
  input  logic [goc_pkg::DIV_W-1:0]  num,
  input  logic [goc_pkg::DIV_W-1:0]  den,
  output logic [goc_pkg::QUO_W-1:0]  quo,
  output logic [goc_pkg::DIV_W-1:0]  rem
);
  import goc_pkg::*;

  logic [DIV_W-1:0]     r   [QUO_STEPS+1];
  logic [DIV_W-1:0]     d   [QUO_STEPS];
  logic [QUO_STEPS-1:0] q   [QUO_STEPS+1];
  logic                 sat [QUO_STEPS+1];

  always_ff @(posedge clk) begin
    r[0]   <= num;
    d[0]   <= den;
    q[0]   <= '0;
    sat[0] <= (num >> QUO_STEPS) >= den;
  end

  for (genvar s = 0; s < QUO_STEPS; s++) begin : g_step
    localparam int B = QUO_STEPS - 1 - s;
    logic                 take;
    logic [QUO_STEPS-1:0] qbit;

    assign take = (r[s] >> B) >= d[s];
    assign qbit = QUO_STEPS'(take) << B;

    always_ff @(posedge clk) begin
      r[s+1]   <= take ? r[s] - (d[s] << B) : r[s];
      q[s+1]   <= q[s] | qbit;
      sat[s+1] <= sat[s];
    end

    if (s < QUO_STEPS - 1) begin : g_den
      always_ff @(posedge clk) begin
        d[s+1] <= d[s];
      end
    end
  end

  assign quo = sat[QUO_STEPS] ? (QUO_W'(1) << QUO_STEPS) : {1'b0, q[QUO_STEPS]};
  assign rem = r[QUO_STEPS];

endmodule

[rtl/gpu_occupancy_calculator_unit.sv]
// ----------------------------------------------------------------------------
// gpu_occupancy_calculator_unit
// Resident blocks per multiprocessor, cooperative count and best trial block
// size with its minimum grid, for one kernel description per transaction.
//
//   channel   ports                        direction  timing
//   command   start, busy, cmd             in         taken on start && !busy
//   result    done, res                    out        one cycle, no back-pressure
//   config    cfg_we, cfg_idx, cfg_data    in         written on cfg_we
//
// A command is taken every cycle; busy stays low.
// A command passes stage 0 and two 12-stage divider pipelines (input
// register plus 11 quotient steps; warp rounding, then the block quotients,
// with stage 1 between them), then single-register stages 2 to 5 and done.
// Reset clears the valid chain and loads the default device limits.
// Nothing stalls: the receiver takes every result as it is shown.
// ----------------------------------------------------------------------------
module gpu_occupancy_calculator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  goc_pkg::cmd_t                 cmd,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [goc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [goc_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output goc_pkg::res_t                 res
);
  import goc_pkg::*;

  // device limits
  logic [12:0] threads_per_sm;
  logic [6:0]  blocks_per_sm_limit;
  logic [6:0]  warp_width;
  logic [16:0] regs_per_sm;
  logic [18:0] smem_per_sm;
  logic [10:0] sm_count;
  logic        coop_supported;

  always_ff @(posedge clk) begin
    if (rst) begin
      threads_per_sm      <= 13'd2048;
      blocks_per_sm_limit <= 7'd32;
      warp_width          <= 7'd32;
      regs_per_sm         <= 17'd65536;
      smem_per_sm         <= 19'd65536;
      sm_count            <= 11'd80;
      coop_supported      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THREADS_PER_SM: threads_per_sm      <= cfg_data[12:0];
        CFG_BLOCKS_LIMIT:   blocks_per_sm_limit <= cfg_data[6:0];
        CFG_WARP_WIDTH:     warp_width          <= cfg_data[6:0];
        CFG_REGS_PER_SM:    regs_per_sm         <= cfg_data[16:0];
        CFG_SMEM_PER_SM:    smem_per_sm         <= cfg_data[18:0];
        CFG_SM_COUNT:       sm_count            <= cfg_data[10:0];
        CFG_COOP_SUPPORTED: coop_supported      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [6:0]  w_eff;
  logic [10:0] mp;
  assign w_eff = (warp_width == '0) ? 7'd1 : warp_width;
  assign mp    = (sm_count == '0) ? 11'd1 : sm_count;
  assign busy  = 1'b0;

  // ---------------------------------------------------------------- stage 0
  logic  v0;
  ctx_t  ctx0;
  ctx_t  ctx_in;

  always_comb begin
    ctx_in.is_function = cmd.is_function;
    ctx_in.regs        = cmd.regs_per_thread;
    ctx_in.smem_total  = DIV_W'(cmd.static_smem_bytes) + DIV_W'(cmd.dynamic_smem_bytes);
    ctx_in.blk_threads = cmd.blk_threads;
    ctx_in.cap         = cmd.kernel_max_threads;
    if (cmd.blk_threads_cap != '0 && cmd.blk_threads_cap < ctx_in.cap)
      ctx_in.cap = cmd.blk_threads_cap;
    if (ctx_in.cap > MAX_BLOCK_THREADS) ctx_in.cap = MAX_BLOCK_THREADS;
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start && !busy;
    ctx0 <= ctx_in;
  end

  // ------------------------------------------- warp rounding (divider A)
  logic [QUO_W-1:0] quo_a [LANES];
  logic [DIV_W-1:0] rem_a [LANES];
  logic             va   [DIV_LAT];
  ctx_t             ctxa [DIV_LAT];

  for (genvar l = 0; l < LANES; l++) begin : g_div_a
    goc_div u_div_a (
      .clk (clk),
      .num (DIV_W'(lane_size(ctx0.blk_threads, l))),
      .den (DIV_W'(w_eff)),
      .quo (quo_a[l]),
      .rem (rem_a[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) va[i] <= 1'b0;
    end else begin
      va[0] <= v0;
      for (int i = 1; i < DIV_LAT; i++) va[i] <= va[i-1];
    end
    ctxa[0] <= ctx0;
    for (int i = 1; i < DIV_LAT; i++) ctxa[i] <= ctxa[i-1];
  end

  // ------------------------------------------- stage 1: registers per block
  logic             v1;
  ctx_t             ctx1;
  logic [DIV_W-1:0] per_block [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_round
    logic [QUO_W-1:0] rnd;
    logic [QUO_W-1:0] pad;
    assign pad = (rem_a[l] == '0) ? '0 : QUO_W'(w_eff) - QUO_W'(rem_a[l][6:0]);
    assign rnd = QUO_W'(lane_size(ctxa[DIV_LAT-1].blk_threads, l)) + pad;
    always_ff @(posedge clk) begin
      per_block[l] <= DIV_W'(ctxa[DIV_LAT-1].regs) * DIV_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= va[DIV_LAT-1];
    ctx1 <= ctxa[DIV_LAT-1];
  end

  // ---------------------------------------- block quotients (divider B)
  logic [QUO_W-1:0] quo_thr [LANES];
  logic [QUO_W-1:0] quo_reg [LANES];
  logic [DIV_W-1:0] rem_thr [LANES];
  logic [DIV_W-1:0] rem_reg [LANES];
  logic [QUO_W-1:0] quo_smem;
  logic [DIV_W-1:0] rem_smem;
  logic             vb   [DIV_LAT];
  ctx_t             ctxb [DIV_LAT];

  for (genvar l = 0; l < LANES; l++) begin : g_div_b
    goc_div u_div_thr (
      .clk (clk),
      .num (DIV_W'(threads_per_sm)),
      .den (DIV_W'(lane_size(ctx1.blk_threads, l))),
      .quo (quo_thr[l]),
      .rem (rem_thr[l])
    );
    goc_div u_div_reg (
      .clk (clk),
      .num (DIV_W'(regs_per_sm)),
      .den (per_block[l]),
      .quo (quo_reg[l]),
      .rem (rem_reg[l])
    );
  end

  goc_div u_div_smem (
    .clk (clk),
    .num (DIV_W'(smem_per_sm)),
    .den (ctx1.smem_total),
    .quo (quo_smem),
    .rem (rem_smem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vb[i] <= 1'b0;
    end else begin
      vb[0] <= v1;
      for (int i = 1; i < DIV_LAT; i++) vb[i] <= vb[i-1];
    end
    ctxb[0] <= ctx1;
    for (int i = 1; i < DIV_LAT; i++) ctxb[i] <= ctxb[i-1];
  end

  // ------------------------------------------- stage 2: minimum of bounds
  logic             v2;
  ctx_t             ctx2;
  logic [BLK_W-1:0] blocks2 [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_min
    logic [QUO_W-1:0] m;
    always_comb begin
      m = quo_thr[l];
      if (QUO_W'(blocks_per_sm_limit) < m) m = QUO_W'(blocks_per_sm_limit);
      if (ctxb[DIV_LAT-1].regs != '0 && quo_reg[l] < m) m = quo_reg[l];
      if (ctxb[DIV_LAT-1].smem_total != '0 && quo_smem < m) m = quo_smem;
    end
    // the block limit keeps the minimum below 128
    always_ff @(posedge clk) begin
      blocks2[l] <= m[BLK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= vb[DIV_LAT-1];
    ctx2 <= ctxb[DIV_LAT-1];
  end

  // ------------------------------------------ stage 3: threads per trial
  logic             v3;
  ctx_t             ctx3;
  logic [BLK_W-1:0] blocks3 [LANES];
  logic [OCC_W-1:0] occ3    [TRIALS];
  logic             fit3    [TRIALS];

  for (genvar t = 0; t < TRIALS; t++) begin : g_occ
    always_ff @(posedge clk) begin
      occ3[t] <= OCC_W'(blocks2[t+1]) * OCC_W'(TRIAL_TABLE[t]);
      fit3[t] <= TRIAL_TABLE[t] <= ctx2.cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    ctx3 <= ctx2;
    for (int l = 0; l < LANES; l++) blocks3[l] <= blocks2[l];
  end

  // ---------------------------------------------- stage 4: pick best trial
  logic              v4;
  ctx_t              ctx4;
  logic [BLK_W-1:0]  active4;
  logic [BLK_W-1:0]  best_blocks4;
  logic [SIZE_W-1:0] best_size4;
  logic [OCC_W-1:0]  best_occ;
  logic [BLK_W-1:0]  best_blocks;
  logic [SIZE_W-1:0] best_size;

  // the default size is the first trial even when nothing fits
  always_comb begin
    best_occ    = '0;
    best_size   = TRIAL_TABLE[0];
    best_blocks = blocks3[1];
    for (int t = 0; t < TRIALS; t++) begin
      if (fit3[t] && occ3[t] > best_occ) begin
        best_occ    = occ3[t];
        best_size   = TRIAL_TABLE[t];
        best_blocks = blocks3[t+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    ctx4         <= ctx3;
    active4      <= blocks3[0];
    best_blocks4 <= best_blocks;
    best_size4   <= best_size;
  end

  // ---------------------------------------------------- stage 5: result
  res_t res_next;

  always_comb begin
    res_next = '0;
    if (!ctx4.is_function) begin
      res_next.status = STATUS_NOT_FN;
    end else begin
      res_next.best_blk_threads = best_size4;
      res_next.min_grid_size    = 23'(best_blocks4) * 23'(mp);
      if (ctx4.blk_threads == '0) begin
        res_next.status = STATUS_BS_ZERO;
      end else begin
        res_next.status            = STATUS_OK;
        res_next.max_active_blocks = 13'(active4);
        if (coop_supported)
          res_next.cooperative_blocks = 23'(active4) * 23'(sm_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v4;
    res <= res_next;
  end

  // ------------------------------------------------------------ checks
  a_best_zero_iff_not_fn: assert property (@(posedge clk) disable iff (rst)
    done |-> ((res.status == STATUS_NOT_FN) == (res.best_blk_threads == '0)))
    else $error("best size and not-a-function status disagree");

  a_active_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.max_active_blocks[12:7] == '0))
    else $error("resident blocks exceed the block limit range");

  a_bs_zero_clears: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == STATUS_BS_ZERO) |->
      (res.max_active_blocks == '0 && res.cooperative_blocks == '0))
    else $error("zero block size transaction carries resident blocks");

  a_best_size_aligned: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != STATUS_NOT_FN) |-> (res.best_blk_threads[4:0] == '0))
    else $error("best size is not a trial size");

endmodule

[verif/gpu_occupancy_calculator_unit_tb.sv]
// ----------------------------------------------------------------------------
// gpu_occupancy_calculator_unit_tb
// Self-checking bench for the occupancy calculator. Kernel descriptions are
// queued and driven as command transactions with random sender gaps. Each
// result is compared against a behavioural occupancy predictor, under several
// device limit settings that include the all-zero and the all-ones extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpu_occupancy_calculator_unit_tb;
  import goc_pkg::*;

  localparam int NO_LIMIT_BLOCKS = 1000000;
  localparam int DEFAULT_BEST    = 32;
  localparam int DRAIN_CYCLES    = 40;
  localparam int STALL_LIMIT     = 2000;

  typedef struct {
    int unsigned thr;
    int unsigned blk;
    int unsigned warp;
    int unsigned regs;
    int unsigned smem;
    int unsigned sms;
    int unsigned coop;
  } dev_limits_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start = 1'b0;
  cmd_t                 cmd = '0;
  logic                 busy;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  res_t                 res;

  dev_limits_t dev;
  cmd_t        pending_cmds[$];
  res_t        expected_res[$];
  int          sender_idle_pct;
  int          errors = 0;
  int          stall_cnt = 0;

  gpu_occupancy_calculator_unit dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .done(done), .res(res)
  );

  always #5 clk = ~clk;

  function automatic int unsigned blocks_resident(int unsigned bs, int unsigned regs,
                                                  int unsigned smem_total);
    int unsigned       best;
    int unsigned       w;
    int unsigned       warps;
    int unsigned       by_regs;
    int unsigned       by_smem;
    longint unsigned   per_block;
    best    = dev.thr / bs;
    by_regs = NO_LIMIT_BLOCKS;
    by_smem = NO_LIMIT_BLOCKS;
    if (dev.blk < best) best = dev.blk;
    if (regs > 0) begin
      w         = (dev.warp != 0) ? dev.warp : 1;
      warps     = (bs + w - 1) / w;
      per_block = longint'(regs) * warps * w;
      if (per_block > 0) by_regs = int'(longint'(dev.regs) / per_block);
    end
    if (smem_total > 0) by_smem = dev.smem / smem_total;
    if (by_regs < best) best = by_regs;
    if (by_smem < best) best = by_smem;
    return best;
  endfunction

  function automatic res_t predict_occupancy(cmd_t c);
    res_t        r;
    int unsigned smem_total;
    int unsigned cap;
    int unsigned best_occ;
    int unsigned best_size;
    int unsigned occ;
    int unsigned act;
    int unsigned mp;
    int unsigned t;
    r = '0;
    if (!c.is_function) begin
      r.status = STATUS_NOT_FN;
      return r;
    end
    smem_total = 32'(c.static_smem_bytes) + 32'(c.dynamic_smem_bytes);
    mp         = (dev.sms != 0) ? dev.sms : 1;
    if (c.blk_threads == 0) begin
      r.status = STATUS_BS_ZERO;
    end else begin
      r.status = STATUS_OK;
      act = blocks_resident(32'(c.blk_threads), 32'(c.regs_per_thread), smem_total);
      r.max_active_blocks = 13'(act);
      if (dev.coop != 0) r.cooperative_blocks = 23'(act * dev.sms);
    end
    cap = 32'(c.kernel_max_threads);
    if (c.blk_threads_cap > 0 && 32'(c.blk_threads_cap) < cap)
      cap = 32'(c.blk_threads_cap);
    if (cap > 32'(MAX_BLOCK_THREADS)) cap = 32'(MAX_BLOCK_THREADS);
    best_size = DEFAULT_BEST;
    best_occ  = 0;
    for (int i = 0; i < TRIALS; i++) begin
      t = 32'(TRIAL_TABLE[i]);
      if (t > cap) break;
      if (t == 0) continue;
      occ = blocks_resident(t, 32'(c.regs_per_thread), smem_total) * t;
      if (occ > best_occ) begin
        best_occ  = occ;
        best_size = t;
      end
    end
    r.best_blk_threads = 11'(best_size);
    r.min_grid_size    = 23'(blocks_resident(best_size, 32'(c.regs_per_thread),
                                             smem_total) * mp);
    return r;
  endfunction

  // driver: account the transaction taken at this edge, then offer the next
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_res.push_back(predict_occupancy(cmd));
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        start <= 1'b1;
        cmd   <= pending_cmds.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, res);
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (res.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, res.status);
        if (res.max_active_blocks !== e.max_active_blocks)
          $display("%0t: max_active_blocks expected %0d actual %0d", $time,
                   e.max_active_blocks, res.max_active_blocks);
        if (res.cooperative_blocks !== e.cooperative_blocks)
          $display("%0t: cooperative_blocks expected %0d actual %0d", $time,
                   e.cooperative_blocks, res.cooperative_blocks);
        if (res.best_blk_threads !== e.best_blk_threads)
          $display("%0t: best_blk_threads expected %0d actual %0d", $time,
                   e.best_blk_threads, res.best_blk_threads);
        if (res.min_grid_size !== e.min_grid_size)
          $display("%0t: min_grid_size expected %0d actual %0d", $time,
                   e.min_grid_size, res.min_grid_size);
        if (res !== e) errors++;
      end
    end
  end

  // watchdog: count cycles with work outstanding but no transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done ||
        (pending_cmds.size() == 0 && expected_res.size() == 0)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_W-1:0];
    case (idx)
      CFG_THREADS_PER_SM: dev.thr  = val & 32'h1FFF;
      CFG_BLOCKS_LIMIT:   dev.blk  = val & 32'h7F;
      CFG_WARP_WIDTH:     dev.warp = val & 32'h7F;
      CFG_REGS_PER_SM:    dev.regs = val & 32'h1FFFF;
      CFG_SMEM_PER_SM:    dev.smem = val & 32'h7FFFF;
      CFG_SM_COUNT:       dev.sms  = val & 32'h7FF;
      CFG_COOP_SUPPORTED: dev.coop = val & 32'h1;
      default: ;
    endcase
  endtask

  task automatic cfg_all(int unsigned thr, int unsigned blk, int unsigned warp,
                         int unsigned regs, int unsigned smem, int unsigned sms,
                         int unsigned coop);
    cfg_write(CFG_THREADS_PER_SM, thr);
    cfg_write(CFG_BLOCKS_LIMIT, blk);
    cfg_write(CFG_WARP_WIDTH, warp);
    cfg_write(CFG_REGS_PER_SM, regs);
    cfg_write(CFG_SMEM_PER_SM, smem);
    cfg_write(CFG_SM_COUNT, sms);
    cfg_write(CFG_COOP_SUPPORTED, coop);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every queued transaction has produced its result
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() != 0 || start || expected_res.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [18:0] rand_smem();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 19'($urandom());
      2:       return 19'($urandom_range(0, 262144));
      default: return 19'($urandom_range(1, 16384));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.is_function = ($urandom_range(0, 99) < 92);
    case ($urandom_range(0, 3))
      0:       c.regs_per_thread = 8'd0;
      1:       c.regs_per_thread = 8'd255;
      default: c.regs_per_thread = 8'($urandom());
    endcase
    c.static_smem_bytes  = rand_smem();
    c.dynamic_smem_bytes = rand_smem();
    case ($urandom_range(0, 9))
      0:       c.blk_threads = '0;
      1:       c.blk_threads = 11'd1024;
      2:       c.blk_threads = 11'($urandom());
      default: c.blk_threads = 11'($urandom_range(1, 1024));
    endcase
    case ($urandom_range(0, 5))
      0, 1:    c.blk_threads_cap = '0;
      2:       c.blk_threads_cap = 11'($urandom());
      default: c.blk_threads_cap = 11'($urandom_range(1, 1024));
    endcase
    c.kernel_max_threads = ($urandom_range(0, 7) == 0) ? 11'($urandom())
                                                       : 11'($urandom_range(0, 1024));
    return c;
  endfunction

  function automatic cmd_t mk_cmd(logic fn, int unsigned regs, int unsigned ss,
                                  int unsigned ds, int unsigned bs, int unsigned lim,
                                  int unsigned kmax);
    cmd_t c;
    c.is_function        = fn;
    c.regs_per_thread    = 8'(regs);
    c.static_smem_bytes  = 19'(ss);
    c.dynamic_smem_bytes = 19'(ds);
    c.blk_threads        = 11'(bs);
    c.blk_threads_cap    = 11'(lim);
    c.kernel_max_threads = 11'(kmax);
    return c;
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_cmds.push_back(rand_cmd());
  endtask

  task automatic cfg_random();
    cfg_all($urandom_range(0, 4096), $urandom_range(0, 64), $urandom_range(0, 64),
            $urandom_range(0, 65536), $urandom_range(0, 262144),
            $urandom_range(0, 1024), $urandom_range(0, 1));
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    sender_idle_pct = 28;
    dev = '{thr: 2048, blk: 32, warp: 32, regs: 65536, smem: 65536, sms: 80, coop: 1};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset limits
    pending_cmds.push_back(mk_cmd(0, 32, 0, 0, 256, 0, 1024));
    pending_cmds.push_back(mk_cmd(1, 32, 0, 0, 0, 0, 1024));
    pending_cmds.push_back(mk_cmd(1, 0, 0, 0, 128, 0, 1024));
    pending_cmds.push_back(mk_cmd(1, 255, 0, 0, 1024, 0, 1024));
    pending_cmds.push_back(mk_cmd(1, 255, 262144, 262144, 1, 1024, 1024));
    pending_cmds.push_back(mk_cmd(1, 32, 1024, 2048, 1, 0, 0));
    pending_cmds.push_back(mk_cmd(1, 64, 0, 4096, 100, 200, 1024));
    pending_cmds.push_back(mk_cmd(1, 16, 512, 0, 33, 1024, 500));
    pending_cmds.push_back(mk_cmd(1, 8, 0, 0, 2047, 2047, 2047));
    pending_cmds.push_back(mk_cmd(1, 1, 19'h7FFFF, 19'h7FFFF, 1023, 31, 1024));
    pending_cmds.push_back(mk_cmd(1, 128, 100, 100, 768, 768, 768));
    pending_cmds.push_back(mk_cmd(0, 255, 19'h7FFFF, 19'h7FFFF, 2047, 2047, 2047));
    drain();

    // directed: warp width zero, no cooperative launch
    cfg_all(4096, 64, 0, 65536, 262144, 0, 0);
    pending_cmds.push_back(mk_cmd(1, 3, 0, 0, 37, 0, 1024));
    pending_cmds.push_back(mk_cmd(1, 0, 0, 1, 1024, 0, 1024));
    pending_cmds.push_back(mk_cmd(1, 255, 0, 0, 0, 64, 1024));
    drain();

    cfg_all(2048, 32, 32, 65536, 65536, 80, 1);
    queue_random(600);
    drain();

    sender_idle_pct = 51;
    cfg_random();
    queue_random(300);
    drain();
    cfg_random();
    queue_random(300);
    drain();

    sender_idle_pct = 0;
    cfg_all(0, 0, 0, 0, 0, 0, 0);
    queue_random(100);
    drain();
    cfg_all(19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF, 19'h7FFFF);
    queue_random(100);
    drain();
    cfg_all(4096, 64, 64, 65536, 262144, 1024, 1);
    queue_random(150);
    drain();
    cfg_random();
    queue_random(200);
    drain();

    if (errors == 0 && expected_res.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[gpu_occupancy_calculator_unit.f]
rtl/goc_pkg.sv
rtl/goc_div.sv
rtl/gpu_occupancy_calculator_unit.sv
verif/gpu_occupancy_calculator_unit_tb.sv
